### rtl/hfd_pkg.sv
// Shared constants for the humidity and temperature frame decoder.
// Depends on nothing; every other file of the block uses it.
package hfd_pkg;

    localparam int ByteWidth    = 8;
    localparam int TickWidth    = 16;
    localparam int ProductWidth = 31;
    localparam int QuotWidth    = 15;
    localparam int TempWidth    = 15;
    localparam int HumWidth     = 14;

    localparam logic [ByteWidth-1:0] CrcInit = 8'hFF;
    localparam logic [ByteWidth-1:0] CrcPoly = 8'h31;

    localparam logic [ProductWidth-1:0] TempScale = 31'd17500;
    localparam logic [ProductWidth-1:0] HumScale  = 31'd12500;

    localparam logic [QuotWidth-1:0] TempOffset = 15'd4500;
    localparam logic [QuotWidth-1:0] HumOffset  = 15'd600;
    localparam logic [QuotWidth-1:0] HumCeil    = 15'd10600;
    localparam logic [HumWidth-1:0]  HumMax     = 14'd10000;

endpackage

### rtl/hfd_frame_if.sv
// Handshake channel that carries one six-byte measurement frame per item.
// Depends on hfd_pkg for the byte width.
interface hfd_frame_if;

    logic                         valid;
    logic                         ready;
    logic [hfd_pkg::ByteWidth-1:0] temp_high;
    logic [hfd_pkg::ByteWidth-1:0] temp_low;
    logic [hfd_pkg::ByteWidth-1:0] temp_check;
    logic [hfd_pkg::ByteWidth-1:0] hum_high;
    logic [hfd_pkg::ByteWidth-1:0] hum_low;
    logic [hfd_pkg::ByteWidth-1:0] hum_check;

    modport source (
        output valid, temp_high, temp_low, temp_check, hum_high, hum_low, hum_check,
        input  ready
    );

    modport sink (
        input  valid, temp_high, temp_low, temp_check, hum_high, hum_low, hum_check,
        output ready
    );

endinterface

### rtl/hfd_result_if.sv
// Handshake channel that carries one decoded temperature and humidity item.
// Depends on hfd_pkg for the field widths.
interface hfd_result_if;

    logic                                valid;
    logic                                ready;
    logic signed [hfd_pkg::TempWidth-1:0] temp_centi;
    logic                                temp_valid;
    logic        [hfd_pkg::HumWidth-1:0]  hum_centi;
    logic                                hum_valid;

    modport source (
        output valid, temp_centi, temp_valid, hum_centi, hum_valid,
        input  ready
    );

    modport sink (
        input  valid, temp_centi, temp_valid, hum_centi, hum_valid,
        output ready
    );

endinterface

### rtl/hfd_crc8_byte.sv
// One byte of the CRC-8 update, polynomial 0x31, most significant bit first.
// Depends on hfd_pkg for the polynomial and the byte width.
module hfd_crc8_byte (
    input  logic [hfd_pkg::ByteWidth-1:0] crc_in,
    input  logic [hfd_pkg::ByteWidth-1:0] data,
    output logic [hfd_pkg::ByteWidth-1:0] crc_out
);
    import hfd_pkg::*;

    logic [ByteWidth-1:0] crc_work;

    always_comb
    begin
        crc_work = crc_in ^ data;
        for (int b = 0; b < ByteWidth; b++)
        begin
            if (crc_work[ByteWidth-1])
            begin
                crc_work = {crc_work[ByteWidth-2:0], 1'b0} ^ CrcPoly;
            end
            else
            begin
                crc_work = {crc_work[ByteWidth-2:0], 1'b0};
            end
        end
        crc_out = crc_work;
    end

endmodule

### rtl/hfd_tick_scale.sv
// Floored division of a scaled tick product by 65535 without a divider.
// Depends on hfd_pkg for the product and quotient widths.
module hfd_tick_scale (
    input  logic [hfd_pkg::ProductWidth-1:0] product,
    output logic [hfd_pkg::QuotWidth-1:0]    quotient
);
    import hfd_pkg::*;

    localparam int SumWidth = ProductWidth + 1;

    logic [SumWidth-1:0] sum;

    // The sum x + floor(x / 2^16) + 1 shifted down by 16 is floor(x / 65535)
    // for every quotient below 2^16.
    assign sum = SumWidth'(product) + SumWidth'(product[ProductWidth-1:TickWidth])
               + SumWidth'(1);
    assign quotient = sum[TickWidth+QuotWidth-1:TickWidth];

endmodule

### rtl/humidity_temp_frame_decode_unit.sv
// Decodes one humidity and temperature measurement frame per item.
// An accepted frame passes through the registered stages s1, s2 and s3 to its result item.
// Throughput is one item per cycle, set by the three register stages, unless result.ready stalls them.
// Reset clears the stage valid bits only; payload registers are not reset.
// Depends on hfd_pkg, hfd_frame_if, hfd_result_if, hfd_crc8_byte, hfd_tick_scale.
module humidity_temp_frame_decode_unit (
    input  logic         clk,
    input  logic         rst_n,
    hfd_frame_if.sink    frame,
    hfd_result_if.source result
);
    import hfd_pkg::*;

    logic                  s1_valid_reg;
    logic [ByteWidth-1:0]  s1_temp_crc_reg;
    logic [ByteWidth-1:0]  s1_hum_crc_reg;
    logic [TickWidth-1:0]  s1_temp_ticks_reg;
    logic [TickWidth-1:0]  s1_hum_ticks_reg;
    logic [ByteWidth-1:0]  s1_temp_check_reg;
    logic [ByteWidth-1:0]  s1_hum_check_reg;
    logic [ByteWidth-1:0]  s1_temp_crc_next;
    logic [ByteWidth-1:0]  s1_hum_crc_next;

    logic                    s2_valid_reg;
    logic                    s2_temp_ok_reg;
    logic                    s2_hum_ok_reg;
    logic [ProductWidth-1:0] s2_temp_prod_reg;
    logic [ProductWidth-1:0] s2_hum_prod_reg;
    logic [ByteWidth-1:0]    s2_temp_crc;
    logic [ByteWidth-1:0]    s2_hum_crc;
    logic                    s2_temp_ok_next;
    logic                    s2_hum_ok_next;
    logic [ProductWidth-1:0] s2_temp_prod_next;
    logic [ProductWidth-1:0] s2_hum_prod_next;

    logic                        s3_valid_reg;
    logic signed [TempWidth-1:0] s3_temp_centi_reg;
    logic                        s3_temp_ok_reg;
    logic [HumWidth-1:0]         s3_hum_centi_reg;
    logic                        s3_hum_ok_reg;
    logic [QuotWidth-1:0]        s3_temp_quot;
    logic [QuotWidth-1:0]        s3_hum_quot;
    logic [QuotWidth-1:0]        s3_hum_diff;
    logic signed [TempWidth-1:0] s3_temp_centi_next;
    logic [HumWidth-1:0]         s3_hum_centi_next;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    assign s3_ready    = !s3_valid_reg || result.ready;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign frame.ready = s1_ready;

    hfd_crc8_byte u_temp_crc_high (
        .crc_in  (CrcInit),
        .data    (frame.temp_high),
        .crc_out (s1_temp_crc_next)
    );

    hfd_crc8_byte u_hum_crc_high (
        .crc_in  (CrcInit),
        .data    (frame.hum_high),
        .crc_out (s1_hum_crc_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= frame.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && frame.valid)
        begin
            s1_temp_crc_reg   <= s1_temp_crc_next;
            s1_hum_crc_reg    <= s1_hum_crc_next;
            s1_temp_ticks_reg <= {frame.temp_high, frame.temp_low};
            s1_hum_ticks_reg  <= {frame.hum_high, frame.hum_low};
            s1_temp_check_reg <= frame.temp_check;
            s1_hum_check_reg  <= frame.hum_check;
        end
    end

    hfd_crc8_byte u_temp_crc_low (
        .crc_in  (s1_temp_crc_reg),
        .data    (s1_temp_ticks_reg[ByteWidth-1:0]),
        .crc_out (s2_temp_crc)
    );

    hfd_crc8_byte u_hum_crc_low (
        .crc_in  (s1_hum_crc_reg),
        .data    (s1_hum_ticks_reg[ByteWidth-1:0]),
        .crc_out (s2_hum_crc)
    );

    assign s2_temp_ok_next   = (s2_temp_crc == s1_temp_check_reg);
    assign s2_hum_ok_next    = (s2_hum_crc == s1_hum_check_reg);
    assign s2_temp_prod_next = ProductWidth'(s1_temp_ticks_reg) * TempScale;
    assign s2_hum_prod_next  = ProductWidth'(s1_hum_ticks_reg) * HumScale;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_temp_ok_reg   <= s2_temp_ok_next;
            s2_hum_ok_reg    <= s2_hum_ok_next;
            s2_temp_prod_reg <= s2_temp_prod_next;
            s2_hum_prod_reg  <= s2_hum_prod_next;
        end
    end

    hfd_tick_scale u_temp_scale (
        .product  (s2_temp_prod_reg),
        .quotient (s3_temp_quot)
    );

    hfd_tick_scale u_hum_scale (
        .product  (s2_hum_prod_reg),
        .quotient (s3_hum_quot)
    );

    assign s3_hum_diff = s3_hum_quot - HumOffset;

    always_comb
    begin
        if (s2_temp_ok_reg)
        begin
            s3_temp_centi_next = TempWidth'(s3_temp_quot - TempOffset);
        end
        else
        begin
            s3_temp_centi_next = '0;
        end

        if (!s2_hum_ok_reg || s3_hum_quot < HumOffset)
        begin
            s3_hum_centi_next = '0;
        end
        else if (s3_hum_quot > HumCeil)
        begin
            s3_hum_centi_next = HumMax;
        end
        else
        begin
            s3_hum_centi_next = s3_hum_diff[HumWidth-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_temp_centi_reg <= s3_temp_centi_next;
            s3_temp_ok_reg    <= s2_temp_ok_reg;
            s3_hum_centi_reg  <= s3_hum_centi_next;
            s3_hum_ok_reg     <= s2_hum_ok_reg;
        end
    end

    assign result.valid      = s3_valid_reg;
    assign result.temp_centi = s3_temp_centi_reg;
    assign result.temp_valid = s3_temp_ok_reg;
    assign result.hum_centi  = s3_hum_centi_reg;
    assign result.hum_valid  = s3_hum_ok_reg;

`ifndef ASSERT_OFF
    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        frame.valid && frame.ready |=> s1_valid_reg)
        else $error("Accepted frame did not reach the first stage.");

    a_stall_holds_stage2: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_ready |=> s2_valid_reg && $stable(s2_temp_prod_reg))
        else $error("Second stage lost its item during a stall.");

    a_bad_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.temp_valid |-> result.temp_centi == '0)
        else $error("Temperature with a failed check is not zero.");

    a_hum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.hum_centi <= HumMax)
        else $error("Humidity exceeds full scale.");
`endif

endmodule
